[rtl/core/triangular_weighted_smoother_core_defines.svh]
// ----------------------------------------------------------------------------
// Triangular weighted smoother assertion macros
// Shared concurrent assertion forms for the smoother core.
// ----------------------------------------------------------------------------
`ifndef TRIANGULAR_WEIGHTED_SMOOTHER_CORE_DEFINES_SVH
`define TRIANGULAR_WEIGHTED_SMOOTHER_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define TWS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tws: same-cycle implication violated");

// Check that a condition implies another in the next cycle
`define TWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tws: next-cycle implication violated");

`endif

[rtl/core/tws_pkg.sv]
// ----------------------------------------------------------------------------
// Triangular weighted smoother package
// Fixed field widths, cell control bundle and sequencer state codes.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TAPCFG_W = 6;
   localparam int FILL_W   = 6;
   localparam logic [FILL_W-1:0] FILL_MAX = '1;

   // Control bundle broadcast to every cell of the row
   typedef struct packed {
      logic shift;
      logic clear;
      logic load_wgt;
   } tws_cell_ctl_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SUM   = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_FLUSH = 4'b1000
   } tws_state_type;

endpackage

[rtl/core/triangular_weighted_smoother_core.sv]
// Flow: each request shifts into the cell row, the partial sum ripples down the row,
//   the bit-serial divider divides it by the weight sum, and the result is loaded
//   into the output register.
// Throughput: one request per cycle while no result is due, else one per result time;
//   the final request adds one result time for each flushed result.
// Reset: synchronous; clears the window, fill count and control, tap count back to 1.
// ----------------------------------------------------------------------------
// Triangular weighted smoother core
// Centered triangular-weighted moving average over a row of sample cells,
// with flush of the delayed results on the last request of a waveform.
// ----------------------------------------------------------------------------
`include "triangular_weighted_smoother_core_defines.svh"

module triangular_weighted_smoother_core import tws_pkg::*; #(
   parameter int MAX_TAPS = 32
) (
   input  logic                clock,
   input  logic                reset,
   // Request stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [15:0] in_sample
   input  logic                req_tlast,   // in_last
   // Result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,   // [15:0] out_sample
   output logic                rsp_tlast,   // out_last
   // Tap count register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [TAPCFG_W-1:0] csr_data
);

   localparam int TAP_W     = $clog2(MAX_TAPS + 1);
   localparam int WGT_W     = $clog2((MAX_TAPS + 1) / 2 + 1);
   localparam int WSUM_MAX  = ((MAX_TAPS + 2) / 2) * ((MAX_TAPS + 2) / 2);
   localparam int WS_W      = $clog2(WSUM_MAX + 1);
   localparam int ACC_W     = 17 + $clog2(WSUM_MAX);
   localparam int CNT_W     = $clog2(MAX_TAPS + 1);
   localparam int PROD_W    = 2 * TAP_W + 2;

   tws_state_type              state_ff, state_in;
   logic [FILL_W-1:0]          fill_ff, fill_in, fill_next;
   logic                       last_ff, last_in;
   logic [TAP_W-1:0]           flush_ff, flush_in;
   logic [TAP_W-1:0]           skip_ff, skip_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [TAP_W-1:0]           delay_ff;
   logic [WS_W-1:0]            wsum_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [TAP_W-1:0]           cfg_taps;
   logic [TAP_W-1:0]           cfg_half;
   logic [TAP_W-1:0]           cfg_delay;
   logic [TAP_W:0]             cfg_half_p1;
   logic [PROD_W-1:0]          cfg_prod;

   tws_cell_ctl_type           cell_ctl;
   logic signed [SAMPLE_W-1:0] shift_sample;
   logic signed [SAMPLE_W-1:0] link_sample [MAX_TAPS];
   logic signed [ACC_W-1:0]    link_psum   [MAX_TAPS];
   logic                       div_start;
   logic                       div_busy;
   logic signed [SAMPLE_W-1:0] div_quotient;

   // Decode a tap count write: clamp, delay and weight sum
   always_comb begin
      if (csr_data == '0) begin
         cfg_taps = TAP_W'(1);
      end else if (32'(csr_data) > MAX_TAPS) begin
         cfg_taps = TAP_W'(MAX_TAPS);
      end else begin
         cfg_taps = TAP_W'(csr_data);
      end
      cfg_half    = cfg_taps >> 1;
      cfg_delay   = cfg_taps - cfg_half - TAP_W'(1);
      cfg_half_p1 = {1'b0, cfg_half} + 1'b1;
      if (cfg_taps[0]) begin
         cfg_prod = PROD_W'(cfg_half_p1) * PROD_W'(cfg_half_p1);
      end else begin
         cfg_prod = PROD_W'(cfg_half) * PROD_W'(cfg_half_p1);
      end
   end

   // Row of sample cells
   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      if (k == 0) begin : g_head
         tws_cell #(
            .IDX   (k),
            .TAP_W (TAP_W),
            .WGT_W (WGT_W),
            .ACC_W (ACC_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .taps       (cfg_taps),
            .sample_in  (shift_sample),
            .sample_out (link_sample[k]),
            .psum_in    ('0),
            .psum_out   (link_psum[k])
         );
      end else begin : g_body
         tws_cell #(
            .IDX   (k),
            .TAP_W (TAP_W),
            .WGT_W (WGT_W),
            .ACC_W (ACC_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .taps       (cfg_taps),
            .sample_in  (link_sample[k-1]),
            .sample_out (link_sample[k]),
            .psum_in    (link_psum[k-1]),
            .psum_out   (link_psum[k])
         );
      end
   end

   // Divide the full weighted sum by the weight sum
   tws_divider #(
      .NUM_W (ACC_W - 1),
      .DEN_W (WS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (link_psum[MAX_TAPS-1]),
      .divisor  (wsum_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // Sequencer: accept, sum, divide, flush
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      last_in       = last_ff;
      flush_in      = flush_ff;
      skip_in       = skip_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      cell_ctl      = '0;
      shift_sample  = '0;
      div_start     = 1'b0;
      fill_next     = (fill_ff == FILL_MAX) ? FILL_MAX : fill_ff + 1'b1;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cell_ctl.shift = 1'b1;
               shift_sample   = req_tdata;
               fill_in        = fill_next;
               last_in        = req_tlast;
               flush_in       = delay_ff;
               cnt_in         = '0;
               if (32'(fill_next) > 32'(delay_ff)) begin
                  skip_in  = '0;
                  state_in = ST_SUM;
               end else begin
                  skip_in  = delay_ff - TAP_W'(fill_next);
                  state_in = req_tlast ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_SUM: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAX_TAPS)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_busy && (!rsp_valid_ff || rsp_tready)) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = div_quotient;
               rsp_last_in   = last_ff && (flush_ff == '0);
               if (last_ff && flush_ff != '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
                  if (last_ff) begin
                     cell_ctl.clear = 1'b1;
                     fill_in        = '0;
                     last_in        = 1'b0;
                  end
               end
            end
         end
         ST_FLUSH: begin
            cell_ctl.shift = 1'b1;
            flush_in       = flush_ff - 1'b1;
            if (skip_ff != '0) begin
               skip_in = skip_ff - 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = ST_SUM;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A tap count write starts a new waveform
      if (csr_valid) begin
         cell_ctl.clear    = 1'b1;
         cell_ctl.load_wgt = 1'b1;
         fill_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         last_ff      <= 1'b0;
         flush_ff     <= '0;
         skip_ff      <= '0;
         cnt_ff       <= '0;
         delay_ff     <= '0;
         wsum_ff      <= WS_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         flush_ff     <= flush_in;
         skip_ff      <= skip_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            delay_ff <= cfg_delay;
            wsum_ff  <= WS_W'(cfg_prod);
         end
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

   // Checks
   `TWS_ASSERT_IMPLY(a_ready_no_divide, clock, reset, req_tready, !div_busy)
   `TWS_ASSERT_IMPLY(a_skip_below_flush, clock, reset, state_ff == ST_FLUSH, skip_ff < flush_ff)
   `TWS_ASSERT_IMPLY(a_rsp_from_div, clock, reset, $rose(rsp_tvalid), $past(state_ff == ST_DIV))
   `TWS_ASSERT_NEXT(a_div_runs, clock, reset, div_start, div_busy && state_ff == ST_DIV)

endmodule

[rtl/core/tws_cell.sv]
// ----------------------------------------------------------------------------
// Smoother cell
// Holds one window sample and its tap weight, adds its weighted sample to
// the partial sum coming from the neighbor and passes it on each cycle.
// ----------------------------------------------------------------------------
module tws_cell import tws_pkg::*; #(
   parameter int IDX   = 0,
   parameter int TAP_W = 6,
   parameter int WGT_W = 5,
   parameter int ACC_W = 26
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tws_cell_ctl_type           ctl,
   input  logic [TAP_W-1:0]           taps,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic signed [SAMPLE_W-1:0] sample_out,
   input  logic signed [ACC_W-1:0]    psum_in,
   output logic signed [ACC_W-1:0]    psum_out
);

   logic signed [SAMPLE_W-1:0]      sample_ff;
   logic [WGT_W-1:0]                weight_ff;
   logic [WGT_W-1:0]                weight_in;
   logic signed [ACC_W-1:0]         psum_ff;
   logic signed [SAMPLE_W+WGT_W:0]  prod;
   logic [TAP_W:0]                  rise;
   logic [TAP_W:0]                  fall;

   // Weight of this tap: min(position from front, position from back)
   always_comb begin
      rise = (TAP_W+1)'(IDX + 1);
      fall = {1'b0, taps} - (TAP_W+1)'(IDX);
      if ({1'b0, taps} > (TAP_W+1)'(IDX)) begin
         weight_in = (rise < fall) ? WGT_W'(rise) : WGT_W'(fall);
      end else begin
         weight_in = '0;
      end
   end

   // Hold the sample; shift from the neighbor or clear; load the tap weight
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         weight_ff <= (IDX == 0) ? WGT_W'(1) : '0;
      end else begin
         if (ctl.clear) begin
            sample_ff <= '0;
         end else if (ctl.shift) begin
            sample_ff <= sample_in;
         end
         if (ctl.load_wgt) begin
            weight_ff <= weight_in;
         end
      end
   end

   // Advance the partial sum along the row
   assign prod = sample_ff * $signed({1'b0, weight_ff});

   always_ff @(posedge clock) begin
      psum_ff <= psum_in + ACC_W'(prod);
   end

   assign sample_out = sample_ff;
   assign psum_out   = psum_ff;

endmodule

[rtl/core/tws_divider.sv]
// ----------------------------------------------------------------------------
// Smoother divider
// Restoring divider, one quotient bit per cycle, quotient truncated toward
// zero and narrowed to the sample width.
// ----------------------------------------------------------------------------
module tws_divider import tws_pkg::*; #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_W:0]      dividend,
   input  logic [DEN_W-1:0]           divisor,
   output logic                       busy,
   output logic signed [SAMPLE_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [NUM_W:0]   mag;
   logic [DEN_W:0]   rem_shift;
   logic             fits;
   logic [DEN_W-1:0] rem_next;

   // Magnitude of the dividend
   assign mag = dividend[NUM_W] ? (~dividend + 1'b1) : dividend;

   // One restoring step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      fits      = (rem_shift >= {1'b0, divisor});
      if (fits) begin
         rem_next = DEN_W'(rem_shift - {1'b0, divisor});
      end else begin
         rem_next = DEN_W'(rem_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
         busy_ff <= 1'b0;
      end
   end

   // Load operands, then iterate
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[NUM_W];
         quo_ff <= mag[NUM_W-1:0];
         rem_ff <= '0;
         cnt_ff <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= rem_next;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign busy     = busy_ff;
   assign quotient = SAMPLE_W'(neg_ff ? (~quo_ff + 1'b1) : quo_ff);

endmodule

[tb/tb_triangular_weighted_smoother_core.sv]
// ----------------------------------------------------------------------------
// Triangular weighted smoother core testbench
// Sends waveform sample requests under several tap counts and checks every
// smoothed result against a local predictor of the triangular average. Both
// stream sides idle at random. Directed cases run first, then random waveforms.
// ----------------------------------------------------------------------------
module tb_triangular_weighted_smoother_core;
   import tws_pkg::*;

   localparam int MAX_TAPS     = 32;
   localparam int FILL_LIMIT   = 63;
   localparam int DRAIN_CYCLES = 100;   // wait after the last expected result is taken
   localparam int RANDOM_ITEMS = 215;
   localparam int PRINT_CAP    = 100;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type S_MAX = 16'sh7FFF;
   localparam sample_type S_MIN = 16'sh8000;

   typedef struct {
      sample_type sample;
      logic       last;
   } smoothed_type;

   typedef enum int {
      SHAPE_RANDOM,
      SHAPE_TOP,
      SHAPE_BOTTOM,
      SHAPE_TOGGLE
   } shape_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata;   // [15:0] in_sample
   logic                req_tlast;   // in_last
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [SAMPLE_W-1:0] rsp_tdata;   // [15:0] out_sample
   logic                rsp_tlast;   // out_last
   logic                csr_valid;
   logic                csr_ready;
   logic [TAPCFG_W-1:0] csr_data;

   // Predictor state
   logic [TAPCFG_W-1:0] tap_reg;
   sample_type          tap_window [MAX_TAPS];
   int                  fill;
   smoothed_type        smoothed_q [$];
   smoothed_type        oldest;

   int                  mismatch_count;
   int                  items_sent;
   bit                  gaps_on;

   triangular_weighted_smoother_core #(
      .MAX_TAPS (MAX_TAPS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void clear_window();
      for (int k = 0; k < MAX_TAPS; k++) tap_window[k] = '0;
      fill = 0;
   endfunction

   function automatic int taps_in_use();
      if (tap_reg == 0) return 1;
      if (tap_reg > MAX_TAPS) return MAX_TAPS;
      return int'(tap_reg);
   endfunction

   function automatic void push_sample(sample_type value);
      for (int k = MAX_TAPS - 1; k > 0; k--) tap_window[k] = tap_window[k-1];
      tap_window[0] = value;
   endfunction

   // Weighted sum over the window, divided by the weight sum toward zero
   function automatic sample_type weighted_mean(int n);
      int h;
      int wsum;
      int acc;
      int w;
      h    = n / 2;
      wsum = (n % 2 == 1) ? (h + 1) * (h + 1) : h * (h + 1);
      acc  = 0;
      for (int k = 0; k < n; k++) begin
         w = (k + 1 < n - k) ? k + 1 : n - k;
         acc += w * int'(tap_window[k]);
      end
      return sample_type'(acc / wsum);
   endfunction

   function automatic void queue_result(sample_type value);
      smoothed_type r;
      r.sample = value;
      r.last   = 1'b0;
      smoothed_q.push_back(r);
   endfunction

   // Advance the window by one request and queue the results it causes
   function automatic void predict_request(sample_type value, logic is_last);
      int           n;
      int           d;
      int           emitted;
      smoothed_type r;
      n       = taps_in_use();
      d       = n - 1 - n / 2;
      emitted = 0;
      push_sample(value);
      if (fill < FILL_LIMIT) fill++;
      if (fill > d) begin
         queue_result(weighted_mean(n));
         emitted++;
      end
      if (is_last) begin
         // Flush the delayed outputs with zero padding
         for (int j = 1; j <= d; j++) begin
            push_sample('0);
            if (fill - 1 + j >= d) begin
               queue_result(weighted_mean(n));
               emitted++;
            end
         end
         if (emitted > 0) begin
            r = smoothed_q.pop_back();
            r.last = 1'b1;
            smoothed_q.push_back(r);
         end
         clear_window();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (smoothed_q.size() == 0) begin
            report_mismatch("result with no request pending", rsp_tdata, 0);
         end else begin
            oldest = smoothed_q.pop_front();
            if (rsp_tdata !== oldest.sample)
               report_mismatch("out_sample", rsp_tdata, oldest.sample);
            if (rsp_tlast !== oldest.last)
               report_mismatch("out_last", rsp_tlast, oldest.last);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Pacing
   // ------------------------------------------------------------------------
   function automatic int next_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Stall the result side at random, with some long open stretches
   initial begin : sink_pacing
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 4) == 0) repeat ($urandom_range(40, 200)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = next_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_sample(input sample_type value, input logic is_last);
      int gap;
      gap = gaps_on ? next_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      predict_request(value, is_last);
      items_sent++;
   endtask

   // Drop the request valid and hold until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (smoothed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_taps(input logic [TAPCFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tap_reg = value;
      clear_window();
   endtask

   function automatic sample_type shaped_sample(shape_type shape, int idx);
      case (shape)
         SHAPE_TOP:    return S_MAX;
         SHAPE_BOTTOM: return S_MIN;
         SHAPE_TOGGLE: return idx[0] ? S_MAX : S_MIN;
         default:      return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_waveform(input int len, input bit finish, input shape_type shape);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++)
         send_sample(shaped_sample(shape, i), finish && (i == len - 1));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset tap count of one copies the input
   task automatic test_copy_after_reset();
      send_sample(S_MAX, 1'b0);
      send_sample(S_MIN, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sh5555, 1'b1);
      drain();
   endtask

   // Tap count zero acts as one; single-sample waveform
   task automatic test_tap_zero();
      write_taps(6'd0);
      send_sample(16'sh2AAA, 1'b1);
      drain();
   endtask

   // Waveform shorter than the delay: everything comes on the last request
   task automatic test_short_waveform();
      write_taps(6'd32);
      send_sample(S_MAX, 1'b0);
      send_sample(S_MIN, 1'b0);
      send_sample(16'sh1234, 1'b1);
      drain();
   endtask

   // Tap count above the window size acts as the window size
   task automatic test_oversized_taps();
      write_taps(6'd63);
      send_sample(S_MAX, 1'b0);
      send_sample(S_MAX, 1'b1);
      drain();
   endtask

   // Small negative averages truncate toward zero
   task automatic test_truncation();
      write_taps(6'd3);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd7, 1'b1);
      drain();
   endtask

   // Tap count write in the middle of a waveform starts a new one
   task automatic test_config_midstream();
      write_taps(6'd5);
      send_sample(16'sh7000, 1'b0);
      send_sample(S_MIN, 1'b0);
      send_sample(16'sh0F0F, 1'b0);
      send_sample(16'shF0F0, 1'b0);
      drain();
      write_taps(6'd2);
      send_sample(16'sh4000, 1'b0);
      send_sample(16'shC001, 1'b0);
      send_sample(S_MAX, 1'b1);
      drain();
   endtask

   // Random phases of tap counts, each with a few waveforms
   task automatic test_random_waveforms();
      logic [TAPCFG_W-1:0] corner_taps [7];
      int                  stop_at;
      int                  waves;
      int                  len;
      int                  roll;
      bit                  finish;
      shape_type           shape;
      corner_taps = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd63};
      stop_at     = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 3) == 0) write_taps(corner_taps[$urandom_range(0, 6)]);
         else write_taps(TAPCFG_W'($urandom_range(0, 63)));
         waves = $urandom_range(1, 4);
         for (int w = 0; w < waves; w++) begin
            roll = $urandom_range(0, 99);
            len  = (roll < 8) ? $urandom_range(64, 72) : $urandom_range(1, 40);
            roll = $urandom_range(0, 9);
            shape = (roll == 0) ? SHAPE_TOP :
                    (roll == 1) ? SHAPE_BOTTOM :
                    (roll == 2) ? SHAPE_TOGGLE : SHAPE_RANDOM;
            // Leave a waveform open now and then; the next write cuts it off
            finish = ($urandom_range(0, 9) != 0);
            send_waveform(len, finish, shape);
            if (!finish) break;
         end
         drain();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : run_tests
      mismatch_count = 0;
      items_sent     = 0;
      gaps_on        = 1'b1;
      tap_reg        = 6'd1;
      clear_window();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_copy_after_reset();
      test_tap_zero();
      test_short_waveform();
      test_oversized_taps();
      test_truncation();
      test_config_midstream();
      test_random_waveforms();
      drain();

      if (mismatch_count == 0 && smoothed_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tws_pkg.sv
rtl/core/tws_cell.sv
rtl/core/tws_divider.sv
rtl/core/triangular_weighted_smoother_core.sv
tb/tb_triangular_weighted_smoother_core.sv
